FILE: rtl/swc_pkg.sv
// ----------------------------------------------------------------------------
// swc_pkg
// Shared types, codes and helpers of the set-associative write-back cache.
// ----------------------------------------------------------------------------
package swc_pkg;

    // Request classes decided by the front end
    localparam logic [1:0] CLS_READ  = 2'd0;
    localparam logic [1:0] CLS_WRITE = 2'd1;
    localparam logic [1:0] CLS_FILL  = 2'd2;
    localparam logic [1:0] CLS_BAD   = 2'd3;

    // Result kinds on the output stream
    localparam logic [2:0] KIND_RDATA  = 3'd0;
    localparam logic [2:0] KIND_WDONE  = 3'd1;
    localparam logic [2:0] KIND_WBACK  = 3'd2;
    localparam logic [2:0] KIND_FILLRQ = 3'd3;
    localparam logic [2:0] KIND_REJECT = 3'd4;

    localparam logic [15:0] SEED_RESET = 16'd44257;

    // Decoded request as it travels through the queue
    typedef struct packed {
        logic [1:0]  cls;
        logic [31:0] addr;
        logic [31:0] wdata;
        logic [31:0] wmask;
        logic [31:0] fdata;
    } item_t;

    // Victim LFSR: x^16+x^14+x^13+x^11+1, shifts left
    function automatic logic [15:0] lfsr_next(input logic [15:0] s);
        logic fb;
        fb = s[15] ^ s[13] ^ s[12] ^ s[10];
        return {s[14:0], fb};
    endfunction

    function automatic logic [31:0] merge_word(input logic [31:0] old,
                                               input logic [31:0] d,
                                               input logic [31:0] m);
        return (d & m) | (old & ~m);
    endfunction

endpackage

FILE: rtl/swc_front.sv
// ----------------------------------------------------------------------------
// swc_front
// Accepts requests, classifies the command and aligns the address.
// ----------------------------------------------------------------------------
module swc_front #(
    parameter int ADDR_WIDTH = 32
) (
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [127:0]       s_tdata,   // address, write_data, write_mask, fill_data
    input  logic [1:0]         s_tuser,   // command
    input  logic               q_full,
    output logic               q_push,
    output swc_pkg::item_t     q_item
);
    import swc_pkg::*;

    localparam logic [31:0] AW_MASK =
        (ADDR_WIDTH >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ADDR_WIDTH) - 64'd1);

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    // Command decode and field unpack
    always_comb begin
        unique case (s_tuser)
            2'd0:    q_item.cls = CLS_READ;
            2'd1:    q_item.cls = CLS_WRITE;
            2'd2:    q_item.cls = CLS_FILL;
            default: q_item.cls = CLS_BAD;
        endcase
        q_item.addr  = s_tdata[31:0] & AW_MASK & 32'hFFFF_FFFC;
        q_item.wdata = s_tdata[63:32];
        q_item.wmask = s_tdata[95:64];
        q_item.fdata = s_tdata[127:96];
    end

endmodule

FILE: rtl/swc_fifo.sv
// ----------------------------------------------------------------------------
// swc_fifo
// Two-entry queue between the front end and the sequencer.
// ----------------------------------------------------------------------------
module swc_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  swc_pkg::item_t     push_item,
    output logic               full,
    input  logic               pop,
    output logic               head_valid,
    output swc_pkg::item_t     head_item
);
    import swc_pkg::*;

    item_t       slot_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_item  = slot_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

FILE: rtl/swc_back.sv
// ----------------------------------------------------------------------------
// swc_back
// Cache sequencer: tag lookup, hit handling, victim choice, write-back,
// fill tracking, tag and data memories and the output register.
// ----------------------------------------------------------------------------
module swc_back #(
    parameter int LINE_BYTES      = 64,
    parameter int CACHE_SIZE_LOG2 = 14,
    parameter int WAYS_LOG2       = 2,
    parameter int ADDR_WIDTH      = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  swc_pkg::item_t     q_item,
    output logic               q_pop,
    input  logic               cfg_wr_en,
    input  logic [15:0]        cfg_wr_data,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [63:0]        m_tdata,   // mem_address, data
    output logic [2:0]         m_tuser,   // kind
    output logic               m_tlast
);
    import swc_pkg::*;

    localparam int LINE_LOG2  = $clog2(LINE_BYTES);
    localparam int WPL_LOG2   = LINE_LOG2 - 2;
    localparam int LINES_LOG2 = CACHE_SIZE_LOG2 - LINE_LOG2;
    localparam int NUM_LINES  = 1 << LINES_LOG2;
    localparam int NUM_WAYS   = 1 << WAYS_LOG2;
    localparam int SET_BITS   = LINES_LOG2 - WAYS_LOG2;
    localparam int NUM_SETS   = 1 << SET_BITS;
    localparam int SET_W      = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int WAY_W      = (WAYS_LOG2 > 0) ? WAYS_LOG2 : 1;
    localparam int TAG_SHIFT  = SET_BITS + LINE_LOG2;
    localparam int AW         = (ADDR_WIDTH < 32) ? ADDR_WIDTH : 32;
    localparam int TAG_W      = (AW > TAG_SHIFT) ? AW - TAG_SHIFT : 1;
    localparam int DADDR_W    = LINES_LOG2 + WPL_LOG2;
    localparam int NUM_WORDS  = 1 << DADDR_W;
    localparam logic [31:0]         SET_MASK  = 32'((64'd1 << SET_BITS) - 64'd1);
    localparam logic [WAY_W-1:0]    WAY_MASK  = WAY_W'(NUM_WAYS - 1);
    localparam logic [WPL_LOG2-1:0] WORD_LAST = '1;
    localparam logic [31:0]         LINE_MASK = ~32'(LINE_BYTES - 1);

    // Sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_HIT    = 3'd2;
    localparam logic [2:0] S_WB_RD  = 3'd3;
    localparam logic [2:0] S_WB_OUT = 3'd4;
    localparam logic [2:0] S_FREQ   = 3'd5;
    localparam logic [2:0] S_FDONE  = 3'd6;

    function automatic logic [DADDR_W-1:0] word_addr(input logic [LINES_LOG2-1:0] ln,
                                                     input logic [WPL_LOG2-1:0] wd);
        return DADDR_W'((32'(ln) << WPL_LOG2) | 32'(wd));
    endfunction

    // Control state
    logic [2:0]            state_reg;
    logic [NUM_LINES-1:0]  valid_reg;
    logic [NUM_LINES-1:0]  dirty_reg;
    logic [15:0]           lfsr_reg;
    logic                  fill_pending_reg;
    logic [WPL_LOG2-1:0]   fill_count_reg;
    logic [WPL_LOG2-1:0]   wb_idx_reg;
    logic                  m_valid_reg;

    // Payload state
    item_t                 cur_reg;
    logic [LINES_LOG2-1:0] op_line_reg;
    logic [DADDR_W-1:0]    op_daddr_reg;
    logic                  op_write_reg;
    logic [31:0]           op_wdata_reg;
    logic [31:0]           op_wmask_reg;
    logic [31:0]           wb_base_reg;
    logic [31:0]           fill_addr_reg;
    logic [2:0]            m_kind_reg;
    logic [31:0]           m_addr_reg;
    logic [31:0]           m_data_reg;
    logic                  m_last_reg;

    // Memories
    logic [TAG_W-1:0]      tag_mem [NUM_WAYS][NUM_SETS];
    logic [TAG_W-1:0]      tag_rd_reg [NUM_WAYS];
    logic [31:0]           data_mem [NUM_WORDS];
    logic [31:0]           dm_rdata_reg;

    logic                  out_ok;
    logic [SET_W-1:0]      q_set;
    logic [SET_W-1:0]      cur_set;
    logic [TAG_W-1:0]      cur_tag;
    logic [WPL_LOG2-1:0]   cur_word;
    logic [LINES_LOG2-1:0] set_base;
    logic [NUM_WAYS-1:0]   way_valid;
    logic                  hit;
    logic [WAY_W-1:0]      hit_way;
    logic                  has_inv;
    logic [WAY_W-1:0]      inv_way;
    logic [15:0]           lfsr_adv;
    logic [WAY_W-1:0]      vic_way;
    logic [LINES_LOG2-1:0] hit_line;
    logic [LINES_LOG2-1:0] vic_line;
    logic                  fill_word;
    logic                  reject;

    logic                  dm_re;
    logic [DADDR_W-1:0]    dm_raddr;
    logic                  dm_we;
    logic [DADDR_W-1:0]    dm_waddr;
    logic [31:0]           dm_wdata;
    logic                  tm_we;

    assign out_ok   = !m_valid_reg || m_tready;
    assign q_pop    = q_valid && ((state_reg == S_IDLE) || ((state_reg == S_HIT) && out_ok));
    assign q_set    = SET_W'((q_item.addr >> LINE_LOG2) & SET_MASK);
    assign cur_set  = SET_W'((cur_reg.addr >> LINE_LOG2) & SET_MASK);
    assign cur_tag  = TAG_W'(cur_reg.addr >> TAG_SHIFT);
    assign cur_word = cur_reg.addr[LINE_LOG2-1:2];
    assign set_base = LINES_LOG2'(32'(cur_set) << WAYS_LOG2);
    assign way_valid = valid_reg[set_base +: NUM_WAYS];
    assign fill_word = (cur_reg.cls == CLS_FILL) && fill_pending_reg;
    assign reject    = !fill_word && ((cur_reg.cls == CLS_FILL) || (cur_reg.cls == CLS_BAD)
                                      || fill_pending_reg);

    // Hit search and victim choice over the ways of one set
    always_comb begin
        hit     = 1'b0;
        hit_way = '0;
        has_inv = 1'b0;
        inv_way = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (!hit && way_valid[w] && (tag_rd_reg[w] == cur_tag)) begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (!has_inv && !way_valid[w]) begin
                has_inv = 1'b1;
                inv_way = WAY_W'(w);
            end
        end
        lfsr_adv = lfsr_next(lfsr_reg);
        vic_way  = has_inv ? inv_way : (WAY_W'(lfsr_adv) & WAY_MASK);
        hit_line = set_base | LINES_LOG2'(hit_way & WAY_MASK);
        vic_line = set_base | LINES_LOG2'(vic_way);
    end

    // Memory port control
    always_comb begin
        dm_re    = 1'b0;
        dm_raddr = op_daddr_reg;
        dm_we    = 1'b0;
        dm_waddr = op_daddr_reg;
        dm_wdata = merge_word(dm_rdata_reg, op_wdata_reg, op_wmask_reg);
        tm_we    = 1'b0;
        unique case (state_reg)
            S_DECIDE: begin
                if (fill_word) begin
                    dm_we    = 1'b1;
                    dm_waddr = word_addr(op_line_reg, fill_count_reg);
                    dm_wdata = cur_reg.fdata;
                end else if (!reject && hit) begin
                    dm_re    = 1'b1;
                    dm_raddr = word_addr(hit_line, cur_word);
                end else if (!reject) begin
                    tm_we    = 1'b1;
                end
            end
            S_HIT: begin
                dm_we = out_ok && op_write_reg;
            end
            S_WB_RD: begin
                dm_re    = 1'b1;
                dm_raddr = word_addr(op_line_reg, wb_idx_reg);
            end
            S_FDONE: begin
                dm_re = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Tag memory: one row per way, all ways read at the queue head's set
    always_ff @(posedge aclk) begin
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (tm_we && (vic_way == WAY_W'(w))) begin
                tag_mem[w][cur_set] <= cur_tag;
            end
            tag_rd_reg[w] <= tag_mem[w][q_set];
        end
    end

    // Data memory
    always_ff @(posedge aclk) begin
        if (dm_we) begin
            data_mem[dm_waddr] <= dm_wdata;
        end
        if (dm_re) begin
            dm_rdata_reg <= data_mem[dm_raddr];
        end
    end

    // Sequencer control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            valid_reg        <= '0;
            dirty_reg        <= '0;
            lfsr_reg         <= SEED_RESET;
            fill_pending_reg <= 1'b0;
            fill_count_reg   <= '0;
            wb_idx_reg       <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (m_tready) m_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (q_pop) state_reg <= S_DECIDE;
                end
                S_DECIDE: begin
                    if (fill_word) begin
                        fill_count_reg <= fill_count_reg + 1'b1;
                        if (fill_count_reg == WORD_LAST) begin
                            fill_pending_reg <= 1'b0;
                            state_reg        <= S_FDONE;
                        end else begin
                            state_reg <= S_IDLE;
                        end
                    end else if (reject) begin
                        if (out_ok) begin
                            m_valid_reg <= 1'b1;
                            state_reg   <= S_IDLE;
                        end
                    end else if (hit) begin
                        state_reg <= S_HIT;
                    end else begin
                        // miss: victim turns valid and clean with the new tag
                        if (!has_inv) lfsr_reg <= lfsr_adv;
                        valid_reg[vic_line] <= 1'b1;
                        dirty_reg[vic_line] <= 1'b0;
                        fill_pending_reg    <= 1'b1;
                        fill_count_reg      <= '0;
                        wb_idx_reg          <= '0;
                        state_reg <= (!has_inv && dirty_reg[vic_line]) ? S_WB_RD : S_FREQ;
                    end
                end
                S_HIT: begin
                    if (out_ok) begin
                        m_valid_reg <= 1'b1;
                        if (op_write_reg) dirty_reg[op_line_reg] <= 1'b1;
                        state_reg <= q_pop ? S_DECIDE : S_IDLE;
                    end
                end
                S_WB_RD: begin
                    state_reg <= S_WB_OUT;
                end
                S_WB_OUT: begin
                    if (out_ok) begin
                        m_valid_reg <= 1'b1;
                        wb_idx_reg  <= wb_idx_reg + 1'b1;
                        state_reg   <= (wb_idx_reg == WORD_LAST) ? S_FREQ : S_WB_RD;
                    end
                end
                S_FREQ: begin
                    if (out_ok) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                S_FDONE: begin
                    state_reg <= S_HIT;
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (cfg_wr_en) lfsr_reg <= cfg_wr_data;
        end
    end

    // Request, operation and result payload
    always_ff @(posedge aclk) begin
        if (q_pop) cur_reg <= q_item;
        if (state_reg == S_DECIDE && !fill_word && !reject) begin
            op_line_reg   <= hit ? hit_line : vic_line;
            op_daddr_reg  <= word_addr(hit ? hit_line : vic_line, cur_word);
            op_write_reg  <= (cur_reg.cls == CLS_WRITE);
            op_wdata_reg  <= cur_reg.wdata;
            op_wmask_reg  <= cur_reg.wmask;
            wb_base_reg   <= (32'(tag_rd_reg[vic_way]) << TAG_SHIFT)
                             | (32'(cur_set) << LINE_LOG2);
            fill_addr_reg <= cur_reg.addr & LINE_MASK;
        end
        if (out_ok) begin
            m_last_reg <= 1'b1;
            m_addr_reg <= '0;
            m_data_reg <= '0;
            priority if (state_reg == S_HIT) begin
                m_kind_reg <= op_write_reg ? KIND_WDONE : KIND_RDATA;
                m_data_reg <= op_write_reg ? 32'd0 : dm_rdata_reg;
            end else if (state_reg == S_WB_OUT) begin
                m_kind_reg <= KIND_WBACK;
                m_addr_reg <= wb_base_reg | (32'(wb_idx_reg) << 2);
                m_data_reg <= dm_rdata_reg;
                m_last_reg <= 1'b0;
            end else if (state_reg == S_FREQ) begin
                m_kind_reg <= KIND_FILLRQ;
                m_addr_reg <= fill_addr_reg;
            end else begin
                m_kind_reg <= KIND_REJECT;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_data_reg, m_addr_reg};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

    // Fill beat counter only runs while a fill is outstanding
    a_fill_count_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !fill_pending_reg |-> (fill_count_reg == '0))
        else $error("fill count moved without a pending fill");

    // Write-back words never close a request
    a_wback_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_kind_reg == KIND_WBACK)) |-> !m_last_reg)
        else $error("write-back word flagged last");

    // Completing a fill clears the pending flag and goes to finish the access
    a_fill_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FDONE) |-> (!fill_pending_reg && $past(fill_word)))
        else $error("fill completion out of order");

endmodule

FILE: rtl/set_assoc_writeback_cache_unit.sv
// Access: a hit reads the data memory after the registered tag read and compare; a miss
// first sends the write-back words of a dirty victim, then a fill request; the access
// completes after the last fill word. Back-to-back hits are set by the registered tag
// read followed by the data read, and output back-pressure can stall them.
// Reset: synchronous active-low aresetn clears valid and dirty bits, the queue
// and the sequencer, and loads the victim LFSR with 44257; no clearing pass.
// ----------------------------------------------------------------------------
// set_assoc_writeback_cache_unit
// Set-associative write-back, write-allocate cache with random replacement.
// ----------------------------------------------------------------------------
module set_assoc_writeback_cache_unit #(
    parameter int LINE_BYTES      = 64,
    parameter int CACHE_SIZE_LOG2 = 14,
    parameter int WAYS_LOG2       = 2,
    parameter int ADDR_WIDTH      = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [127:0]  s_tdata,   // address, write_data, write_mask, fill_data
    input  logic [1:0]    s_tuser,   // command
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [63:0]   m_tdata,   // mem_address, data
    output logic [2:0]    m_tuser,   // kind
    output logic          m_tlast,
    input  logic          cfg_wr_en,
    input  logic [15:0]   cfg_wr_data
);
    import swc_pkg::*;

    logic   q_full;
    logic   q_push;
    item_t  q_in;
    logic   q_pop;
    logic   q_valid;
    item_t  q_head;

    swc_front #(.ADDR_WIDTH(ADDR_WIDTH)) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (q_in)
    );

    swc_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_item  (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_item  (q_head)
    );

    swc_back #(
        .LINE_BYTES      (LINE_BYTES),
        .CACHE_SIZE_LOG2 (CACHE_SIZE_LOG2),
        .WAYS_LOG2       (WAYS_LOG2),
        .ADDR_WIDTH      (ADDR_WIDTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_item      (q_head),
        .q_pop       (q_pop),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule
